[rtl/hough_line_vote_accumulator_defines.svh]
// assertion macros for the hough line vote accumulator
`ifndef HOUGH_LINE_VOTE_ACCUMULATOR_DEFINES_SVH
`define HOUGH_LINE_VOTE_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define HLVA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hlva assertion failed");
`define HLVA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("hlva assertion failed");
`else
`define HLVA_ASSERT(lbl, prop)
`define HLVA_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

[rtl/hlva_pkg.sv]
// types, constants and codes shared by the hough line vote accumulator
package hlva_pkg;

  localparam int NUM_SLOPES = 21;
  localparam int MAX_DIM    = 256;
  localparam int ROW_BINS   = 2 * MAX_DIM + 1;
  localparam int RAM_DEPTH  = NUM_SLOPES * ROW_BINS;
  localparam int ADDR_W     = $clog2(RAM_DEPTH);
  localparam int SLOPE_W    = $clog2(NUM_SLOPES);
  localparam int COUNT_W    = 17;
  localparam int DIM_W      = 9;
  localparam int BIN_W      = 10;
  localparam int Q_W        = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [7:0]         RED_SKIP  = 8'd255;

  localparam logic [1:0] OP_VOTE  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CFG_WIDTH     = 2'd0;
  localparam logic [1:0] CFG_HEIGHT    = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] pixel_red;
    logic [4:0] slope_index;
    logic [9:0] intercept_index;
  } in_item_t;

  typedef struct packed {
    logic [16:0] bin_count;
    logic        is_line;
    logic        bin_valid;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_QREAD,
    ST_QOUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic step_vote;
    logic issue_query;
    logic load_result;
    logic clear_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_slope;
    logic clear_done;
    logic out_free;
  } ctl_sts_t;

endpackage

[rtl/hlva_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module hlva_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/hlva_ctrl.sv]
// controller state machine for the hough line vote accumulator
module hlva_ctrl import hlva_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_stall,
  input  ctl_sts_t   sts,
  output ctl_cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (opcode)
            OP_VOTE:  state_next = ST_VOTE;
            OP_QUERY: state_next = ST_QREAD;
            OP_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_VOTE: begin
        cmd.step_vote = 1'b1;
        if (sts.last_slope) begin
          state_next = ST_IDLE;
        end
      end
      ST_QREAD: begin
        cmd.issue_query = 1'b1;
        state_next      = ST_QOUT;
      end
      ST_QOUT: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

[rtl/hlva_datapath.sv]
// datapath: configuration, vote address stepping, vote store and result register
module hlva_datapath import hlva_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  in_item_t     in_item,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data,
  input  ctl_cmd_t     cmd,
  output ctl_sts_t     sts,
  output logic         out_valid,
  input  logic         out_stall,
  output out_item_t    out_item
);

  // configuration
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [COUNT_W-1:0] vote_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(MAX_DIM);
      image_height   <= DIM_W'(MAX_DIM);
      vote_threshold <= COUNT_W'(100);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WIDTH:     image_width    <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:    image_height   <= cfg_data[DIM_W-1:0];
        CFG_THRESHOLD: vote_threshold <= cfg_data[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [BIN_W-1:0] last_bin;

  always_comb begin
    w_eff = image_width;
    if (image_width == '0) w_eff = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
    h_eff = image_height;
    if (image_height == '0) h_eff = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
  end

  assign last_bin = BIN_W'(w_eff) + BIN_W'(h_eff);

  // captured item
  in_item_t item;
  logic [4:0] xq;
  logic [3:0] xr;
  logic [15:0] x_prod;
  logic [4:0]  xq_new;

  // x / 10 by reciprocal
  assign x_prod = 16'(in_item.pixel_x) * 16'd205;
  assign xq_new = x_prod[15:11];

  // vote stepping: u = 10*q + r, one slope row per step
  logic signed [Q_W-1:0] q;
  logic [3:0]            r;
  logic [SLOPE_W-1:0]    k;
  logic [ADDR_W-1:0]     row_base;
  logic [4:0]            r_diff;
  logic                  borrow;

  assign r_diff = {1'b0, r} - {1'b0, xr};
  assign borrow = r_diff[4];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item     <= in_item;
      xq       <= xq_new;
      xr       <= 4'(in_item.pixel_x - (8'(xq_new) * 8'd10));
      q        <= Q_W'(in_item.pixel_x) + Q_W'(in_item.pixel_y)
                  + Q_W'(w_eff >> 1) + Q_W'(w_eff[0]);
      r        <= w_eff[0] ? 4'd0 : 4'd5;
      k        <= '0;
      row_base <= '0;
    end else if (cmd.step_vote) begin
      r        <= borrow ? (r_diff[3:0] + 4'd10) : r_diff[3:0];
      q        <= q - Q_W'(xq) - Q_W'(borrow);
      k        <= k + SLOPE_W'(1);
      row_base <= row_base + ADDR_W'(ROW_BINS);
    end
  end

  logic vote_ok;
  logic hit;
  logic [ADDR_W-1:0] vote_addr;

  assign vote_ok = (item.pixel_red != RED_SKIP)
                   && (DIM_W'(item.pixel_x) < w_eff)
                   && (DIM_W'(item.pixel_y) < h_eff);
  assign hit = vote_ok && (r != 4'd0) && !q[Q_W-1]
               && (q[BIN_W-1:0] <= last_bin);
  assign vote_addr = row_base + ADDR_W'(q[BIN_W-1:0]);

  // query
  logic              q_valid;
  logic [ADDR_W-1:0] query_addr;

  assign q_valid = (item.slope_index < 5'(NUM_SLOPES))
                   && (item.intercept_index <= last_bin);
  assign query_addr = ADDR_W'(item.slope_index) * ADDR_W'(ROW_BINS)
                      + ADDR_W'(item.intercept_index);

  // clearing sweep
  logic [ADDR_W-1:0] clear_ptr;

  always_ff @(posedge clk) begin
    if (rst || cmd.load_item) begin
      clear_ptr <= '0;
    end else if (cmd.clear_step) begin
      clear_ptr <= clear_ptr + ADDR_W'(1);
    end
  end

  // read-modify-write of one bin per row
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.step_vote && hit;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= vote_addr;
  end

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] count_inc;

  assign count_inc = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_W'(1);
  assign ram_we    = cmd.clear_step || wr_pend;
  assign ram_waddr = cmd.clear_step ? clear_ptr : wr_addr;
  assign ram_wdata = cmd.clear_step ? '0 : count_inc;
  assign ram_re    = cmd.issue_query || (cmd.step_vote && hit);
  assign ram_raddr = cmd.issue_query ? query_addr : vote_addr;

  hlva_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_item.bin_count <= q_valid ? ram_rdata : '0;
      out_item.is_line   <= q_valid && (ram_rdata > vote_threshold);
      out_item.bin_valid <= q_valid;
    end
  end

  assign sts.last_slope = (k == SLOPE_W'(NUM_SLOPES - 1));
  assign sts.clear_done = (clear_ptr == ADDR_W'(RAM_DEPTH - 1));
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

[rtl/hough_line_vote_accumulator.sv]
// top level of the hough line vote accumulator
// Slope-intercept Hough vote store: 21 slope rows of 513 intercept bins of
// 17-bit saturating counters in one memory. A vote item steps through the slope
// rows, reading the bin it hits in each row through the single read port of the
// store, the write-back of each row overlapping the next read.
// A query item reads its bin, then waits for the result register to empty.
// A clear item sweeps the store one bin a cycle, and the same sweep runs after
// reset, during which no item is taken; configuration writes are taken at any
// time the block is idle.
`include "hough_line_vote_accumulator_defines.svh"

module hough_line_vote_accumulator import hlva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  hlva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (in_item.opcode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlva_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  `HLVA_ASSERT(a_load_on_accept, cmd.load_item |-> (in_valid && !in_stall))
  `HLVA_ASSERT(a_result_slot_free, cmd.load_result |-> sts.out_free)
  `HLVA_ASSERT_NEXT(a_vote_ends, cmd.step_vote && sts.last_slope, !cmd.step_vote)
  `HLVA_ASSERT(a_ram_exclusive, cmd.clear_step |-> !(cmd.step_vote || cmd.issue_query))

endmodule

[verif/hough_line_vote_accumulator_test.sv]
// testbench for the hough line vote accumulator: directed and random items against a predictor
module hough_line_vote_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hlva_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 90;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_CYCLES = 30;
  localparam int QUIET_LIMIT = 40000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  hough_line_vote_accumulator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1ns;
    clk = 1'b1;
    #1ns;
  end

  // predictor state
  logic [COUNT_W-1:0] vote_store [RAM_DEPTH];
  logic [DIM_W-1:0]   width_reg = 9'd256;
  logic [DIM_W-1:0]   height_reg = 9'd256;
  logic [COUNT_W-1:0] threshold_reg = 17'd100;
  out_item_t          answers_due [$];
  logic [15:0]        voted_spots [$];

  int faults = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;
  int holds_asked = 0;

  function automatic int dim_in_use(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // distance to the first bin edge, in tenths
  function automatic int scaled_offset(input int x, input int y, input int k, input int w);
    return 10 * y - (k - 10) * x + 5 * w + 5;
  endfunction

  function automatic void account_item(input in_item_t item);
    int w, h, last, k, u, addr;
    out_item_t ans;
    w = dim_in_use(width_reg);
    h = dim_in_use(height_reg);
    last = w + h;
    case (item.opcode)
      OP_VOTE: begin
        if (item.pixel_red != RED_SKIP && item.pixel_x < w && item.pixel_y < h) begin
          for (k = 0; k < NUM_SLOPES; k++) begin
            u = scaled_offset(item.pixel_x, item.pixel_y, k, w);
            if (u >= 0 && u % 10 != 0 && u / 10 <= last) begin
              addr = k * ROW_BINS + u / 10;
              if (vote_store[addr] != COUNT_MAX) vote_store[addr] = vote_store[addr] + 1'b1;
            end
          end
        end
      end
      OP_QUERY: begin
        ans = '0;
        if (item.slope_index < NUM_SLOPES && int'(item.intercept_index) <= last) begin
          ans.bin_count = vote_store[item.slope_index * ROW_BINS + item.intercept_index];
          ans.bin_valid = 1'b1;
          ans.is_line = ans.bin_count > threshold_reg;
        end
        answers_due.push_back(ans);
      end
      OP_CLEAR: begin
        foreach (vote_store[a]) vote_store[a] = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t pick_item(input int vote_pct, input int query_pct,
                                         input bit allow_clear);
    in_item_t item;
    logic [63:0] noise;
    logic [15:0] spot;
    int w, h, r, u, k;
    noise = {$urandom, $urandom};
    item = noise[$bits(in_item_t)-1:0];
    w = dim_in_use(width_reg);
    h = dim_in_use(height_reg);
    r = $urandom_range(0, 99);
    if (r < vote_pct) begin
      item.opcode = OP_VOTE;
      if (voted_spots.size() != 0 && $urandom_range(0, 99) < 40) begin
        {item.pixel_x, item.pixel_y} = voted_spots[$urandom_range(0, voted_spots.size() - 1)];
      end else if ($urandom_range(0, 6) != 0) begin
        item.pixel_x = 8'($urandom_range(0, w - 1));
        item.pixel_y = 8'($urandom_range(0, h - 1));
      end
      item.pixel_red = ($urandom_range(0, 11) == 0) ? RED_SKIP : 8'($urandom_range(0, 254));
      if (item.pixel_red != RED_SKIP && item.pixel_x < w && item.pixel_y < h) begin
        voted_spots.push_back({item.pixel_x, item.pixel_y});
        if (voted_spots.size() > 24) void'(voted_spots.pop_front());
      end
    end else if (r < vote_pct + query_pct) begin
      item.opcode = OP_QUERY;
      if (voted_spots.size() != 0 && $urandom_range(0, 99) < 65) begin
        spot = voted_spots[$urandom_range(0, voted_spots.size() - 1)];
        k = $urandom_range(0, NUM_SLOPES - 1);
        u = scaled_offset(spot[15:8], spot[7:0], k, w);
        item.slope_index = 5'(k);
        item.intercept_index = (u < 10) ? 10'd0 : 10'(u / 10 + $urandom_range(0, 2) - 1);
      end else if ($urandom_range(0, 3) != 0) begin
        item.slope_index = 5'($urandom_range(0, NUM_SLOPES - 1));
        item.intercept_index = 10'($urandom_range(0, w + h + 1));
      end
    end else if (allow_clear && r == 99) begin
      item.opcode = OP_CLEAR;
      voted_spots.delete();
    end else begin
      item.opcode = OP_SPARE;
    end
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = (sender_steady || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    account_item(item);
  endtask

  task automatic vote_at(input int x, input int y, input int red);
    in_item_t item;
    item = '0;
    item.opcode = OP_VOTE;
    item.pixel_x = 8'(x);
    item.pixel_y = 8'(y);
    item.pixel_red = 8'(red);
    send_item(item);
  endtask

  task automatic query_at(input int k, input int i);
    in_item_t item;
    item = '0;
    item.opcode = OP_QUERY;
    item.slope_index = 5'(k);
    item.intercept_index = 10'(i);
    send_item(item);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [16:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      CFG_WIDTH:     width_reg = value[DIM_W-1:0];
      CFG_HEIGHT:    height_reg = value[DIM_W-1:0];
      CFG_THRESHOLD: threshold_reg = value;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // a last query marks the point where the block has finished all earlier items
  task automatic drain_answers();
    send_item(pick_item(0, 100, 1'b0));
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_power_up();
    query_at(10, 128);
    query_at(20, 512);
    query_at(20, 513);
    drain_answers();
  endtask

  task automatic test_vote_corners();
    in_item_t item;
    vote_at(0, 0, 0);
    vote_at(255, 255, 254);
    vote_at(255, 0, 128);
    vote_at(5, 0, 1);
    vote_at(7, 7, RED_SKIP);
    item = '1;
    item.opcode = OP_SPARE;
    send_item(item);
    query_at(10, 128);
    query_at(11, 128);
    query_at(11, 127);
    query_at(0, 512);
    query_at(31, 1023);
    query_at(21, 0);
    drain_answers();
  endtask

  task automatic test_clear_store();
    in_item_t item;
    item = '0;
    item.opcode = OP_CLEAR;
    send_item(item);
    query_at(10, 128);
    query_at(0, 511);
    drain_answers();
  endtask

  task automatic test_image_limits();
    write_reg(CFG_WIDTH, 17'd1);
    write_reg(CFG_HEIGHT, 17'd1);
    write_reg(CFG_THRESHOLD, 17'd0);
    vote_at(0, 0, 0);
    vote_at(1, 0, 0);
    vote_at(0, 1, 0);
    query_at(10, 1);
    query_at(10, 2);
    query_at(10, 3);
    drain_answers();
    write_reg(CFG_WIDTH, 17'd2);
    write_reg(CFG_HEIGHT, 17'd2);
    vote_at(1, 1, 0);
    query_at(10, 2);
    query_at(15, 2);
    drain_answers();
  endtask

  task automatic test_random_phases();
    int p, sent;
    logic [16:0] wv, hv, tv;
    in_item_t item;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin wv = 17'd256; hv = 17'd256; tv = 17'd100; end
        1: begin wv = 17'd8; hv = 17'd8; tv = 17'd2; end
        2: begin wv = 17'd0; hv = 17'd511; tv = 17'd131071; end
        3: begin wv = 17'd511; hv = 17'd1; tv = 17'd0; end
        4: begin wv = 17'h1FE10; hv = 17'd40; tv = 17'd3; end
        5: begin wv = 17'd100; hv = 17'd200; tv = 17'd65536; end
        6: begin
          wv = 17'($urandom_range(1, 64));
          hv = 17'($urandom_range(1, 64));
          tv = 17'($urandom_range(0, 6));
        end
        default: begin
          wv = 17'($urandom_range(1, 256));
          hv = 17'($urandom_range(1, 256));
          tv = 17'($urandom_range(0, 3));
        end
      endcase
      write_reg(CFG_WIDTH, wv);
      write_reg(CFG_HEIGHT, hv);
      write_reg(CFG_THRESHOLD, tv);
      voted_spots.delete();
      sender_steady = (p == 3 || p == 6);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        item = pick_item(52, 40, 1'b1);
        send_item(item);
        if (item.opcode != OP_SPARE) sent++;
      end
      drain_answers();
    end
    sender_steady = 1'b0;
  endtask

  task automatic test_result_backpressure();
    holds_asked <= holds_asked + 1;
    repeat (30) send_item(pick_item(30, 70, 1'b0));
    drain_answers();
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int holds_seen = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      hold_left <= 0;
    end else if (holds_seen != holds_asked) begin
      holds_seen <= holds_asked;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  out_item_t due;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        if (faults < 10)
          $display("unexpected result: count %0d line %0b valid %0b",
                   out_item.bin_count, out_item.is_line, out_item.bin_valid);
        faults++;
      end else begin
        due = answers_due.pop_front();
        if (out_item.bin_count !== due.bin_count || out_item.is_line !== due.is_line ||
            out_item.bin_valid !== due.bin_valid) begin
          if (faults < 10)
            $display("result mismatch: expected count %0d line %0b valid %0b, got count %0d line %0b valid %0b",
                     due.bin_count, due.is_line, due.bin_valid,
                     out_item.bin_count, out_item.is_line, out_item.bin_valid);
          faults++;
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("hough_line_vote_accumulator_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_data <= '0;
    foreach (vote_store[a]) vote_store[a] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_up();
    test_vote_corners();
    test_clear_store();
    test_image_limits();
    test_random_phases();
    test_result_backpressure();
    if (faults == 0 && answers_due.size() == 0) begin
      $display("hough_line_vote_accumulator_test passed");
    end else begin
      $display("hough_line_vote_accumulator_test failed");
    end
    $finish;
  end

endmodule

[hough_line_vote_accumulator.f]
+incdir+rtl
rtl/hlva_pkg.sv
rtl/hlva_ram.sv
rtl/hlva_ctrl.sv
rtl/hlva_datapath.sv
rtl/hough_line_vote_accumulator.sv
verif/hough_line_vote_accumulator_test.sv
